@@ rtl/core/bscf_pkg.sv @@
// ----------------------------------------------------------------------------
// bscf_pkg
// Shared constants, types and the byte-wide CRC-32 update for the framer.
// ----------------------------------------------------------------------------
package bscf_pkg;

  localparam logic [7:0]  MARK_START = 8'hCA;
  localparam logic [7:0]  MARK_ESC   = 8'hCC;
  localparam logic [7:0]  MARK_END   = 8'hDD;
  localparam logic [7:0]  MARK_CRC   = 8'hFD;
  localparam logic [31:0] CRC_POLY   = 32'h04C11DB7;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int CRC_BYTES   = 4;
  localparam int CIDX_W      = $clog2(CRC_BYTES);

  // One accepted item, classified, with the CRC already folded in.
  typedef struct packed {
    logic        first;
    logic        last;
    logic [7:0]  data;
    logic [7:0]  dest;
    logic [7:0]  src;
    logic [31:0] crc;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[31] ^ b[i];
      c  = {c[30:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic logic is_special(input logic [7:0] b);
    return (b == MARK_START) || (b == MARK_ESC) || (b == MARK_END) || (b == MARK_CRC);
  endfunction

endpackage

@@ rtl/core/bscf_in_if.sv @@
// ----------------------------------------------------------------------------
// bscf_in_if
// Payload channel: one payload byte per item with frame addresses and flag.
// ----------------------------------------------------------------------------
interface bscf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic [7:0] dest_addr;
  logic [7:0] src_addr;
  logic       last_byte;

  modport source (output valid, output payload_byte, output dest_addr,
                  output src_addr, output last_byte, input ready);
  modport sink   (input valid, input payload_byte, input dest_addr,
                  input src_addr, input last_byte, output ready);
endinterface

@@ rtl/core/bscf_out_if.sv @@
// ----------------------------------------------------------------------------
// bscf_out_if
// Stream channel: one byte of the stuffed framed stream per item.
// ----------------------------------------------------------------------------
interface bscf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_end;

  modport source (output valid, output out_byte, output run_last,
                  output frame_end, input ready);
  modport sink   (input valid, input out_byte, input run_last,
                  input frame_end, output ready);
endinterface

@@ rtl/core/byte_stuffed_crc32_framer.sv @@
// ----------------------------------------------------------------------------
// byte_stuffed_crc32_framer
// Byte-stuffing framer with start marker, addresses, and a CRC-32 trailer.
// ----------------------------------------------------------------------------
// Usage:
//   payload: one payload byte per item; dest_addr/src_addr are taken on the
//     first item of a frame, last_byte closes the frame.
//   stream:  one output byte per item; run_last marks the final byte caused
//     by an input item, frame_end marks the closing DD of a frame.
// The front accepts one item per cycle while its 4-entry command queue has
// room and folds the byte into the CRC in the same cycle. The back emits one
// stream byte per cycle while the receiver takes them; escaped bytes get a CC
// before them, a frame's first item adds the CA markers and addresses, and
// its last item adds FD, the CRC bytes and the closing DD markers.
// Sustained rate is set by the back's one-byte-per-cycle output register.
// Reset clears frame state, CRC, queue and the output stage; the next item
// starts a new frame. When the receiver stalls, the output byte holds, the
// back stops, the queue fills, and then payload ready drops.
// ----------------------------------------------------------------------------
module byte_stuffed_crc32_framer
  import bscf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  bscf_in_if.sink    payload,
  bscf_out_if.source stream
);

  logic    push;
  logic    pop;
  cmd_t    wr_cmd;
  cmd_t    rd_cmd;
  q_stat_t q_stat;

  bscf_front u_front (
    .clk     (clk),
    .rst     (rst),
    .payload (payload),
    .q_stat  (q_stat),
    .push    (push),
    .cmd     (wr_cmd)
  );

  bscf_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .rd_cmd (rd_cmd),
    .stat   (q_stat)
  );

  bscf_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_cmd  (rd_cmd),
    .q_stat (q_stat),
    .pop    (pop),
    .stream (stream)
  );

endmodule

@@ rtl/core/bscf_queue.sv @@
// ----------------------------------------------------------------------------
// bscf_queue
// Small command FIFO between the front and back parts of the framer.
// ----------------------------------------------------------------------------
module bscf_queue
  import bscf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  cmd_t    wr_cmd,
  input  logic    pop,
  output cmd_t    rd_cmd,
  output q_stat_t stat
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign stat.full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_cmd     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W+1)'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

@@ rtl/core/bscf_front.sv @@
// ----------------------------------------------------------------------------
// bscf_front
// Accepts payload items, tracks frame state and the running CRC, and queues
// one classified command per item.
// ----------------------------------------------------------------------------
module bscf_front
  import bscf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  bscf_in_if.sink payload,
  input  q_stat_t q_stat,
  output logic    push,
  output cmd_t    cmd
);

  logic        in_frame;
  logic [31:0] crc_accum;
  logic [31:0] crc_next;

  assign payload.ready = !q_stat.full;
  assign push          = payload.valid && payload.ready;
  assign crc_next      = crc_byte(in_frame ? crc_accum : 32'h0, payload.payload_byte);

  assign cmd.first = !in_frame;
  assign cmd.last  = payload.last_byte;
  assign cmd.data  = payload.payload_byte;
  assign cmd.dest  = payload.dest_addr;
  assign cmd.src   = payload.src_addr;
  assign cmd.crc   = crc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame  <= 1'b0;
      crc_accum <= '0;
    end else if (push) begin
      if (payload.last_byte) begin
        in_frame  <= 1'b0;
        crc_accum <= '0;
      end else begin
        in_frame  <= 1'b1;
        crc_accum <= crc_next;
      end
    end
  end

endmodule

@@ rtl/core/bscf_back.sv @@
// ----------------------------------------------------------------------------
// bscf_back
// Expands queued commands into the stuffed byte stream, one byte per cycle
// while the receiver accepts, into a registered output stage.
// ----------------------------------------------------------------------------
module bscf_back
  import bscf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      q_cmd,
  input  q_stat_t   q_stat,
  output logic      pop,
  bscf_out_if.source stream
);

  typedef enum logic [8:0] {
    PH_SOF0 = 9'b000000001,
    PH_SOF1 = 9'b000000010,
    PH_DEST = 9'b000000100,
    PH_SRC  = 9'b000001000,
    PH_DATA = 9'b000010000,
    PH_FD   = 9'b000100000,
    PH_CRC  = 9'b001000000,
    PH_END0 = 9'b010000000,
    PH_END1 = 9'b100000000
  } phase_t;

  cmd_t              cmd;
  logic              cmd_valid;
  phase_t            phase;
  phase_t            phase_next;
  logic              esc_done;
  logic [CIDX_W-1:0] crc_idx;

  logic       adv;
  logic       stuffed;
  logic [7:0] cur_byte;
  logic [7:0] crc_sel;
  logic       need_esc;
  logic       step_done;
  logic       item_done;
  logic       end_w;
  logic [7:0] emit_byte;

  assign crc_sel = cmd.crc[crc_idx*8 +: 8];

  always_comb begin
    stuffed    = 1'b0;
    cur_byte   = MARK_START;
    phase_next = phase;
    unique case (phase)
      PH_SOF0: begin
        phase_next = PH_SOF1;
      end
      PH_SOF1: begin
        phase_next = PH_DEST;
      end
      PH_DEST: begin
        stuffed    = 1'b1;
        cur_byte   = cmd.dest;
        phase_next = PH_SRC;
      end
      PH_SRC: begin
        stuffed    = 1'b1;
        cur_byte   = cmd.src;
        phase_next = PH_DATA;
      end
      PH_DATA: begin
        stuffed    = 1'b1;
        cur_byte   = cmd.data;
        phase_next = cmd.last ? PH_FD : PH_DATA;
      end
      PH_FD: begin
        cur_byte   = MARK_CRC;
        phase_next = PH_CRC;
      end
      PH_CRC: begin
        stuffed    = 1'b1;
        cur_byte   = crc_sel;
        phase_next = (crc_idx == CIDX_W'(CRC_BYTES - 1)) ? PH_END0 : PH_CRC;
      end
      PH_END0: begin
        cur_byte   = MARK_END;
        phase_next = PH_END1;
      end
      PH_END1: begin
        cur_byte   = MARK_END;
        phase_next = PH_SOF0;
      end
      default: begin
        phase_next = PH_SOF0;
      end
    endcase
  end

  assign adv       = cmd_valid && (!stream.valid || stream.ready);
  assign need_esc  = stuffed && is_special(cur_byte) && !esc_done;
  assign step_done = !need_esc;
  assign emit_byte = need_esc ? MARK_ESC : cur_byte;
  assign item_done = step_done && (((phase == PH_DATA) && !cmd.last) || (phase == PH_END1));
  assign end_w     = step_done && (phase == PH_END1);
  assign pop       = !q_stat.empty && (!cmd_valid || (adv && item_done));

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      phase     <= PH_SOF0;
      esc_done  <= 1'b0;
      crc_idx   <= '0;
    end else if (pop) begin
      cmd_valid <= 1'b1;
      phase     <= q_cmd.first ? PH_SOF0 : PH_DATA;
      esc_done  <= 1'b0;
      crc_idx   <= '0;
    end else if (adv) begin
      if (need_esc) begin
        esc_done <= 1'b1;
      end else begin
        esc_done <= 1'b0;
        phase    <= phase_next;
        if (phase == PH_CRC) begin
          crc_idx <= crc_idx + 1'b1;
        end
      end
      if (item_done) begin
        cmd_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= q_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stream.valid <= 1'b0;
    end else if (adv) begin
      stream.valid <= 1'b1;
    end else if (stream.ready) begin
      stream.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stream.out_byte  <= emit_byte;
      stream.run_last  <= item_done;
      stream.frame_end <= end_w;
    end
  end

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    stream.valid && stream.frame_end |-> stream.run_last)
    else $error("frame end without run end");

  a_esc_phase: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && esc_done |->
      (phase == PH_DEST) || (phase == PH_SRC) || (phase == PH_DATA) || (phase == PH_CRC))
    else $error("escape pending outside a stuffed field");

  a_esc_follow: assert property (@(posedge clk) disable iff (rst)
    adv && need_esc && !pop |=> esc_done && cmd_valid)
    else $error("escaped byte lost");

endmodule
